// ----- design/ctst_pkg.sv -----
// shared types, constants and helper functions for the countdown timer slot table
// no dependencies; imported by every module of the block
`default_nettype none

package ctst_pkg;

   // table geometry
   localparam int SLOTS       = 16;
   localparam int COUNT_BITS  = 16;
   localparam int IDX_BITS    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // input func codes
   localparam logic [2:0] FUNC_ADD    = 3'd0;
   localparam logic [2:0] FUNC_PAUSE  = 3'd1;
   localparam logic [2:0] FUNC_RESUME = 3'd2;
   localparam logic [2:0] FUNC_CANCEL = 3'd3;
   localparam logic [2:0] FUNC_REAP   = 3'd4;
   localparam logic [2:0] FUNC_TICK   = 3'd5;

   // input start state codes
   localparam logic [1:0] START_RUN    = 2'd0;
   localparam logic [1:0] START_PAUSE  = 2'd1;
   localparam logic [1:0] START_CANCEL = 2'd2;
   localparam logic [1:0] START_BAD    = 2'd3;

   typedef enum logic [2:0] {
      OP_ADD,
      OP_PAUSE,
      OP_RESUME,
      OP_CANCEL,
      OP_REAP,
      OP_TICK,
      OP_BAD
   } op_type;

   typedef enum logic [1:0] {
      MODE_RUN    = 2'd0,
      MODE_PAUSE  = 2'd1,
      MODE_CANCEL = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_INVALID = 3'd1,
      ST_FULL    = 3'd2,
      ST_ALREADY = 3'd3,
      ST_NOTFIN  = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      KIND_REPLY     = 2'd0,
      KIND_EXPIRED   = 2'd1,
      KIND_TICK_NONE = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_WALK,
      BACK_DONE
   } back_state_type;

   // channel payloads
   typedef struct packed {
      logic [2:0]  func;
      logic [3:0]  slot;
      logic [15:0] interval;
      logic [1:0]  start_state;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [2:0] status;
      logic [3:0] result_slot;
      logic       last;
   } rsp_type;

   // classified command, front to back
   typedef struct packed {
      op_type                  op;
      logic [3:0]              slot;
      logic [IDX_BITS-1:0]     idx;
      logic                    slot_ok;
      logic                    add_bad;
      mode_type                start_mode;
      logic [COUNT_BITS-1:0]   count;
   } cmd_type;

   // slot field to table index
   function automatic logic [IDX_BITS-1:0] to_idx(input logic [3:0] s);
      logic [IDX_BITS+3:0] wide;
      wide = {{IDX_BITS{1'b0}}, s};
      return wide[IDX_BITS-1:0];
   endfunction

   // table index to result slot field
   function automatic logic [3:0] to_slot(input logic [IDX_BITS-1:0] i);
      logic [IDX_BITS+3:0] wide;
      wide = {4'b0000, i};
      return wide[3:0];
   endfunction

   // clamp interval into the counter width
   function automatic logic [COUNT_BITS-1:0] sat_count(input logic [15:0] iv);
      logic [COUNT_BITS+15:0] wide;
      logic [COUNT_BITS+15:0] top;
      wide = {{COUNT_BITS{1'b0}}, iv};
      top  = {16'h0000, {COUNT_BITS{1'b1}}};
      if (wide > top) begin
         return {COUNT_BITS{1'b1}};
      end
      return wide[COUNT_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

// ----- design/ctst_front.sv -----
// front end: takes request transfers and classifies them into commands
// depends on ctst_pkg; feeds ctst_queue
`default_nettype none

module ctst_front (
   input  wire               req_valid,
   output logic              req_stall,
   input  ctst_pkg::req_type req_data,
   output logic              push,
   output ctst_pkg::cmd_type push_cmd,
   input  wire               queue_full
);
   import ctst_pkg::*;

   // stall only on a full queue
   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   // decode and precheck the request
   always_comb begin
      push_cmd.slot       = req_data.slot;
      push_cmd.idx        = to_idx(req_data.slot);
      push_cmd.count      = sat_count(req_data.interval);
      push_cmd.add_bad    = (req_data.interval == 16'h0000) ||
                            (req_data.start_state == START_BAD);
      push_cmd.slot_ok    = ({28'd0, req_data.slot} < 32'(SLOTS));
      case (req_data.start_state)
         START_RUN:    push_cmd.start_mode = MODE_RUN;
         START_PAUSE:  push_cmd.start_mode = MODE_PAUSE;
         START_CANCEL: push_cmd.start_mode = MODE_CANCEL;
         default:      push_cmd.start_mode = MODE_CANCEL;
      endcase
      case (req_data.func)
         FUNC_ADD:    push_cmd.op = OP_ADD;
         FUNC_PAUSE:  push_cmd.op = OP_PAUSE;
         FUNC_RESUME: push_cmd.op = OP_RESUME;
         FUNC_CANCEL: push_cmd.op = OP_CANCEL;
         FUNC_REAP:   push_cmd.op = OP_REAP;
         FUNC_TICK:   push_cmd.op = OP_TICK;
         default:     push_cmd.op = OP_BAD;
      endcase
   end

endmodule

`default_nettype wire

// ----- design/ctst_queue.sv -----
// short command queue between front and back
// depends on ctst_pkg for depth and command type
`default_nettype none

module ctst_queue (
   input  wire               clock,
   input  wire               reset,
   input  wire               push,
   input  ctst_pkg::cmd_type push_cmd,
   output logic              full,
   input  wire               pop,
   output logic              pop_valid,
   output ctst_pkg::cmd_type pop_cmd
);
   import ctst_pkg::*;

   cmd_type               entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]  count_ff, count_in;
   logic                  do_push, do_pop;

   assign full      = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_cmd   = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// ----- design/ctst_back.sv -----
// back end: timer table, command execution, tick walk and result register
// depends on ctst_pkg; takes commands from ctst_queue
`default_nettype none

module ctst_back (
   input  wire               clock,
   input  wire               reset,
   input  wire               cmd_valid,
   input  ctst_pkg::cmd_type cmd,
   output logic              cmd_pop,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output ctst_pkg::rsp_type rsp_data
);
   import ctst_pkg::*;

   // table state
   logic [SLOTS-1:0]       used_ff, used_in;
   mode_type               mode_ff  [SLOTS];
   logic [COUNT_BITS-1:0]  ticks_ff [SLOTS];

   // sequencer state
   back_state_type         state_ff, state_in;
   logic [IDX_BITS-1:0]    walk_ff, walk_in;
   logic                   pend_ff, pend_in;
   logic [IDX_BITS-1:0]    pend_idx_ff, pend_idx_in;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;
   logic                   rsp_load;

   // table write port
   logic                   mode_we, ticks_we;
   logic [IDX_BITS-1:0]    wr_idx;
   mode_type               wr_mode;
   logic [COUNT_BITS-1:0]  wr_ticks;

   logic                   out_free;
   logic [IDX_BITS-1:0]    rd_idx;
   mode_type               rd_mode;
   logic                   rd_used;
   logic [COUNT_BITS-1:0]  rd_ticks;
   logic [COUNT_BITS-1:0]  ticks_dec;
   logic                   walk_live;
   logic                   expire;
   logic                   walk_end;
   logic [IDX_BITS-1:0]    free_idx;
   logic                   all_used;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // one read index, shared by walk and named-slot commands
   assign rd_idx    = (state_ff == BACK_WALK) ? walk_ff : cmd.idx;
   assign rd_mode   = mode_ff[rd_idx];
   assign rd_used   = used_ff[rd_idx];
   assign rd_ticks  = ticks_ff[rd_idx];
   assign ticks_dec = (rd_ticks != '0) ? rd_ticks - 1'b1 : '0;
   assign walk_live = rd_used && (rd_mode == MODE_RUN);
   assign expire    = walk_live && (ticks_dec == '0);
   assign walk_end  = (walk_ff == IDX_BITS'(SLOTS - 1));
   assign all_used  = &used_ff;

   // lowest free slot
   always_comb begin
      free_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_idx = IDX_BITS'(i);
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BACK_IDLE: begin
            if (cmd_valid && out_free && (cmd.op == OP_TICK)) begin
               state_in = BACK_WALK;
            end
         end
         BACK_WALK: begin
            if (out_free && walk_end) begin
               state_in = BACK_DONE;
            end
         end
         BACK_DONE: begin
            if (out_free) begin
               state_in = BACK_IDLE;
            end
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      cmd_pop     = 1'b0;
      rsp_load    = 1'b0;
      rsp_in      = rsp_ff;
      used_in     = used_ff;
      walk_in     = walk_ff;
      pend_in     = pend_ff;
      pend_idx_in = pend_idx_ff;
      mode_we     = 1'b0;
      ticks_we    = 1'b0;
      wr_idx      = rd_idx;
      wr_mode     = MODE_CANCEL;
      wr_ticks    = ticks_dec;
      case (state_ff)
         BACK_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_pop            = 1'b1;
               rsp_in.kind        = KIND_REPLY;
               rsp_in.last        = 1'b1;
               rsp_in.result_slot = cmd.slot;
               rsp_in.status      = ST_INVALID;
               case (cmd.op)
                  OP_TICK: begin
                     walk_in = '0;
                     pend_in = 1'b0;
                  end
                  OP_ADD: begin
                     rsp_load           = 1'b1;
                     rsp_in.result_slot = 4'd0;
                     if (cmd.add_bad) begin
                        rsp_in.status = ST_INVALID;
                     end else if (all_used) begin
                        rsp_in.status = ST_FULL;
                     end else begin
                        rsp_in.status      = ST_OK;
                        rsp_in.result_slot = to_slot(free_idx);
                        used_in[free_idx]  = 1'b1;
                        wr_idx             = free_idx;
                        mode_we            = 1'b1;
                        wr_mode            = cmd.start_mode;
                        ticks_we           = 1'b1;
                        wr_ticks           = cmd.count;
                     end
                  end
                  OP_PAUSE: begin
                     rsp_load = 1'b1;
                     if (cmd.slot_ok && rd_used) begin
                        if (rd_mode == MODE_CANCEL) begin
                           rsp_in.status = ST_INVALID;
                        end else if (rd_mode == MODE_PAUSE) begin
                           rsp_in.status = ST_ALREADY;
                        end else begin
                           rsp_in.status = ST_OK;
                           mode_we       = 1'b1;
                           wr_mode       = MODE_PAUSE;
                        end
                     end
                  end
                  OP_RESUME: begin
                     rsp_load = 1'b1;
                     if (cmd.slot_ok && rd_used && (rd_mode != MODE_CANCEL)) begin
                        rsp_in.status = ST_OK;
                        mode_we       = 1'b1;
                        wr_mode       = MODE_RUN;
                     end
                  end
                  OP_CANCEL: begin
                     rsp_load = 1'b1;
                     if (cmd.slot_ok && rd_used) begin
                        if (rd_mode == MODE_CANCEL) begin
                           rsp_in.status = ST_ALREADY;
                        end else begin
                           rsp_in.status = ST_OK;
                           mode_we       = 1'b1;
                           wr_mode       = MODE_CANCEL;
                        end
                     end
                  end
                  OP_REAP: begin
                     rsp_load = 1'b1;
                     if (cmd.slot_ok && rd_used) begin
                        if (rd_mode != MODE_CANCEL) begin
                           rsp_in.status = ST_NOTFIN;
                        end else begin
                           rsp_in.status   = ST_OK;
                           used_in[cmd.idx] = 1'b0;
                        end
                     end
                  end
                  default: begin
                     rsp_load           = 1'b1;
                     rsp_in.result_slot = 4'd0;
                  end
               endcase
            end
         end
         BACK_WALK: begin
            // one slot per cycle while results are not held; an expiry is held until the next one shows up
            if (out_free) begin
               walk_in = walk_ff + 1'b1;
               if (walk_live) begin
                  ticks_we = 1'b1;
                  wr_ticks = ticks_dec;
               end
               if (expire) begin
                  mode_we     = 1'b1;
                  wr_mode     = MODE_CANCEL;
                  pend_in     = 1'b1;
                  pend_idx_in = walk_ff;
                  if (pend_ff) begin
                     rsp_load           = 1'b1;
                     rsp_in.kind        = KIND_EXPIRED;
                     rsp_in.status      = ST_OK;
                     rsp_in.result_slot = to_slot(pend_idx_ff);
                     rsp_in.last        = 1'b0;
                  end
               end
            end
         end
         BACK_DONE: begin
            // flush the held expiry as the final result, or report a quiet tick
            if (out_free) begin
               rsp_load      = 1'b1;
               rsp_in.status = ST_OK;
               rsp_in.last   = 1'b1;
               if (pend_ff) begin
                  rsp_in.kind        = KIND_EXPIRED;
                  rsp_in.result_slot = to_slot(pend_idx_ff);
               end else begin
                  rsp_in.kind        = KIND_TICK_NONE;
                  rsp_in.result_slot = 4'd0;
               end
            end
         end
         default: begin
            pend_in = 1'b0;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_valid_ff && rsp_stall);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         used_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers and table entries, no reset
   always_ff @(posedge clock) begin
      walk_ff     <= walk_in;
      pend_idx_ff <= pend_idx_in;
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
      if (mode_we) begin
         mode_ff[wr_idx] <= wr_mode;
      end
      if (ticks_we) begin
         ticks_ff[wr_idx] <= wr_ticks;
      end
   end

endmodule

`default_nettype wire

// ----- design/countdown_timer_slot_table.sv -----
// countdown timer slot table, top level; depends on ctst_pkg, ctst_front, ctst_queue, ctst_back
// path: a command reply is registered in the queue and then in the result register;
// a tick walks the table, one slot a cycle, then ends in the done state with its last result
// rate: one command a cycle while results are not held; a tick holds the queue until
// its walk and done state are through; results stall the walk when held
// reset: synchronous, clears slot usage, queue, sequencer and result valid
`default_nettype none

module countdown_timer_slot_table (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   input  ctst_pkg::req_type req_data,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output ctst_pkg::rsp_type rsp_data
);
   import ctst_pkg::*;

   logic    push;
   cmd_type push_cmd;
   logic    queue_full;
   logic    pop;
   logic    pop_valid;
   cmd_type pop_cmd;

   ctst_front u_front (
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .push       (push),
      .push_cmd   (push_cmd),
      .queue_full (queue_full)
   );

   ctst_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (queue_full),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_cmd   (pop_cmd)
   );

   ctst_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (pop_valid),
      .cmd       (pop_cmd),
      .cmd_pop   (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
// self-checking testbench for countdown_timer_slot_table: directed steps, then random commands
// predicts results from its own copy of the timer table, takes typed replies from the steps, checks each rsp transfer
// depends on ctst_pkg and countdown_timer_slot_table
`timescale 1ns / 100ps

module tb;
   import ctst_pkg::*;

   // run shape
   localparam int RANDOM_ITEMS   = 205;
   localparam int HOLD_CYCLES    = 240;
   localparam int TAIL_CYCLES    = 2 * (SLOTS + 2) + 8;
   localparam int CYCLE_LIMIT    = 500000;
   localparam int PRINT_LIMIT    = 100;

   // codes the package leaves unnamed
   localparam logic [2:0] FUNC_BAD_LO = 3'd6;
   localparam logic [2:0] FUNC_BAD_HI = 3'd7;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // directed step marks
   localparam logic TYPED     = 1'b1;
   localparam logic PREDICTED = 1'b0;

   typedef struct packed {
      req_type req;
      logic    typed;
      rsp_type want;
   } directed_step_type;

   localparam int DIRECTED_COUNT = 25;

   // directed steps; typed rows carry their reply, the others go through the predictor
   directed_step_type directed_steps [DIRECTED_COUNT] = '{
      '{'{FUNC_TICK,   4'd0,  16'h0000, START_RUN},    TYPED,
        '{KIND_TICK_NONE, ST_OK,      4'd0,  1'b1}},
      '{'{FUNC_PAUSE,  4'd0,  16'h0000, START_RUN},    TYPED,
        '{KIND_REPLY,     ST_INVALID, 4'd0,  1'b1}},
      '{'{FUNC_REAP,   4'd15, 16'hffff, START_BAD},    TYPED,
        '{KIND_REPLY,     ST_INVALID, 4'd15, 1'b1}},
      '{'{FUNC_CANCEL, 4'd7,  16'h0000, START_RUN},    TYPED,
        '{KIND_REPLY,     ST_INVALID, 4'd7,  1'b1}},
      '{'{FUNC_ADD,    4'd15, 16'h0000, START_RUN},    TYPED,
        '{KIND_REPLY,     ST_INVALID, 4'd0,  1'b1}},
      '{'{FUNC_ADD,    4'd0,  16'h0005, START_BAD},    TYPED,
        '{KIND_REPLY,     ST_INVALID, 4'd0,  1'b1}},
      '{'{FUNC_BAD_LO, 4'd15, 16'hffff, START_BAD},    TYPED,
        '{KIND_REPLY,     ST_INVALID, 4'd0,  1'b1}},
      '{'{FUNC_BAD_HI, 4'd10, 16'haaaa, START_PAUSE},  TYPED,
        '{KIND_REPLY,     ST_INVALID, 4'd0,  1'b1}},
      '{'{FUNC_ADD,    4'd15, 16'h0001, START_RUN},    TYPED,
        '{KIND_REPLY,     ST_OK,      4'd0,  1'b1}},
      '{'{FUNC_ADD,    4'd0,  16'hffff, START_PAUSE},  TYPED,
        '{KIND_REPLY,     ST_OK,      4'd1,  1'b1}},
      '{'{FUNC_ADD,    4'd5,  16'h0002, START_CANCEL}, TYPED,
        '{KIND_REPLY,     ST_OK,      4'd2,  1'b1}},
      '{'{FUNC_ADD,    4'd10, 16'h0003, START_RUN},    TYPED,
        '{KIND_REPLY,     ST_OK,      4'd3,  1'b1}},
      '{'{FUNC_TICK,   4'd0,  16'h0000, START_RUN},    PREDICTED, '0},
      '{'{FUNC_PAUSE,  4'd1,  16'h0000, START_RUN},    PREDICTED, '0},
      '{'{FUNC_RESUME, 4'd1,  16'h0000, START_RUN},    PREDICTED, '0},
      '{'{FUNC_RESUME, 4'd3,  16'h0000, START_RUN},    PREDICTED, '0},
      '{'{FUNC_PAUSE,  4'd3,  16'h0000, START_RUN},    PREDICTED, '0},
      '{'{FUNC_RESUME, 4'd0,  16'h0000, START_RUN},    PREDICTED, '0},
      '{'{FUNC_PAUSE,  4'd2,  16'h0000, START_RUN},    PREDICTED, '0},
      '{'{FUNC_CANCEL, 4'd2,  16'h0000, START_RUN},    PREDICTED, '0},
      '{'{FUNC_CANCEL, 4'd1,  16'h0000, START_RUN},    PREDICTED, '0},
      '{'{FUNC_REAP,   4'd3,  16'h0000, START_RUN},    PREDICTED, '0},
      '{'{FUNC_REAP,   4'd0,  16'h0000, START_RUN},    PREDICTED, '0},
      '{'{FUNC_REAP,   4'd0,  16'h0000, START_RUN},    PREDICTED, '0},
      '{'{FUNC_ADD,    4'd9,  16'h5555, START_RUN},    PREDICTED, '0}
   };

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   // predicted copy of the timer table
   logic                  timer_used  [SLOTS];
   mode_type              timer_mode  [SLOTS];
   logic [COUNT_BITS-1:0] timer_count [SLOTS];

   rsp_type expected_results [$];
   rsp_type step_results [$];
   rsp_type want_result;

   int  mismatch_count;
   int  results_seen;
   int  cycle_count;
   int  burst_left;
   bit  long_hold_due;

   countdown_timer_slot_table uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      if (mismatch_count < PRINT_LIMIT) begin
         $display("mismatch: %s", msg);
      end
      mismatch_count++;
   endtask

   // results of one command against the predicted table, left in step_results
   function automatic void predict_timer_results(input req_type r);
      rsp_type    held;
      bit         have_held;
      int         found;
      status_type st;
      held = '0;
      have_held = 0;
      found = -1;
      st = ST_OK;
      step_results.delete();
      if (r.func == FUNC_TICK) begin
         // walk upward; each runnable timer counts down, expiry at zero
         for (int i = 0; i < SLOTS; i++) begin
            if (timer_used[i] && timer_mode[i] == MODE_RUN) begin
               if (timer_count[i] != '0) begin
                  timer_count[i] = timer_count[i] - 1'b1;
               end
               if (timer_count[i] == '0) begin
                  timer_mode[i] = MODE_CANCEL;
                  if (have_held) begin
                     step_results.push_back(held);
                  end
                  held = '{KIND_EXPIRED, ST_OK, 4'(i), 1'b0};
                  have_held = 1;
               end
            end
         end
         if (have_held) begin
            held.last = 1'b1;
            step_results.push_back(held);
         end else begin
            step_results.push_back('{KIND_TICK_NONE, ST_OK, 4'd0, 1'b1});
         end
      end else if (r.func == FUNC_ADD) begin
         // lowest free slot, bad interval or start state rejected first
         if (r.interval == 16'h0000 || r.start_state == START_BAD) begin
            step_results.push_back('{KIND_REPLY, ST_INVALID, 4'd0, 1'b1});
         end else begin
            for (int i = SLOTS - 1; i >= 0; i--) begin
               if (!timer_used[i]) begin
                  found = i;
               end
            end
            if (found < 0) begin
               step_results.push_back('{KIND_REPLY, ST_FULL, 4'd0, 1'b1});
            end else begin
               timer_used[found] = 1'b1;
               timer_mode[found] = mode_type'(r.start_state);
               if (32'(r.interval) > 32'(COUNT_MAX)) begin
                  timer_count[found] = COUNT_MAX;
               end else begin
                  timer_count[found] = COUNT_BITS'(r.interval);
               end
               step_results.push_back('{KIND_REPLY, ST_OK, 4'(found), 1'b1});
            end
         end
      end else if (r.func > FUNC_TICK) begin
         step_results.push_back('{KIND_REPLY, ST_INVALID, 4'd0, 1'b1});
      end else begin
         // named slot commands, reply echoes the slot
         if (int'(r.slot) >= SLOTS || !timer_used[r.slot]) begin
            st = ST_INVALID;
         end else begin
            case (r.func)
               FUNC_PAUSE: begin
                  if (timer_mode[r.slot] == MODE_CANCEL) begin
                     st = ST_INVALID;
                  end else if (timer_mode[r.slot] == MODE_PAUSE) begin
                     st = ST_ALREADY;
                  end else begin
                     timer_mode[r.slot] = MODE_PAUSE;
                  end
               end
               FUNC_RESUME: begin
                  if (timer_mode[r.slot] == MODE_CANCEL) begin
                     st = ST_INVALID;
                  end else begin
                     timer_mode[r.slot] = MODE_RUN;
                  end
               end
               FUNC_CANCEL: begin
                  if (timer_mode[r.slot] == MODE_CANCEL) begin
                     st = ST_ALREADY;
                  end else begin
                     timer_mode[r.slot] = MODE_CANCEL;
                  end
               end
               default: begin
                  if (timer_mode[r.slot] != MODE_CANCEL) begin
                     st = ST_NOTFIN;
                  end else begin
                     timer_used[r.slot] = 1'b0;
                  end
               end
            endcase
         end
         step_results.push_back('{KIND_REPLY, st, r.slot, 1'b1});
      end
   endfunction

   // random command aimed mostly at live slots of the predicted table
   function automatic req_type next_random_request();
      req_type r;
      int      pick;
      int      add_share;
      int      live [$];
      int      finished [$];
      for (int i = 0; i < SLOTS; i++) begin
         if (timer_used[i]) begin
            live.push_back(i);
            if (timer_mode[i] == MODE_CANCEL) begin
               finished.push_back(i);
            end
         end
      end
      r.func = FUNC_TICK;
      r.slot = 4'($urandom_range(0, 15));
      r.interval = 16'($urandom);
      r.start_state = 2'($urandom_range(0, 3));
      add_share = (live.size() > 12) ? 20 : 45;
      pick = $urandom_range(0, 99);
      if (pick < add_share) begin
         r.func = FUNC_ADD;
         pick = $urandom_range(0, 99);
         if (pick < 6) begin
            r.interval = 16'h0000;
         end else if (pick < 80) begin
            r.interval = 16'($urandom_range(1, 6));
         end
         pick = $urandom_range(0, 99);
         if (pick < 65) begin
            r.start_state = START_RUN;
         end else if (pick < 78) begin
            r.start_state = START_PAUSE;
         end else if (pick < 90) begin
            r.start_state = START_CANCEL;
         end else begin
            r.start_state = START_BAD;
         end
      end else if (pick < 68) begin
         r.func = FUNC_TICK;
      end else if (pick < 95) begin
         case ($urandom_range(0, 4))
            0: r.func = FUNC_PAUSE;
            1: r.func = FUNC_RESUME;
            2: r.func = FUNC_CANCEL;
            default: r.func = FUNC_REAP;
         endcase
         if (r.func == FUNC_REAP && finished.size() != 0 && $urandom_range(0, 9) < 8) begin
            r.slot = 4'(finished[$urandom_range(0, finished.size() - 1)]);
         end else if (live.size() != 0 && $urandom_range(0, 9) < 8) begin
            r.slot = 4'(live[$urandom_range(0, live.size() - 1)]);
         end
      end else begin
         r.func = 3'($urandom_range(FUNC_BAD_LO, FUNC_BAD_HI));
      end
      return r;
   endfunction

   // offer one command, predict on its transfer, then pace the next burst
   task automatic offer(input req_type r, input logic typed, input rsp_type want);
      int gap;
      req_data <= r;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      predict_timer_results(r);
      if (typed) begin
         expected_results.push_back(want);
      end else begin
         foreach (step_results[k]) begin
            expected_results.push_back(step_results[k]);
         end
      end
      if (burst_left == 0) begin
         gap = $urandom_range(1, 10);
         burst_left = $urandom_range(0, 24);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end else begin
         burst_left--;
      end
   endtask

   // sender holds off until every predicted result has arrived
   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // stimulus
   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      mismatch_count = 0;
      results_seen = 0;
      long_hold_due = 0;
      burst_left = $urandom_range(0, 24);
      for (int i = 0; i < SLOTS; i++) begin
         timer_used[i] = 1'b0;
         timer_mode[i] = MODE_RUN;
         timer_count[i] = '0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_steps[n]) begin
         offer(directed_steps[n].req, directed_steps[n].typed, directed_steps[n].want);
      end
      drain_results();
      long_hold_due = 1;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 2) begin
            drain_results();
         end
         offer(next_random_request(), PREDICTED, '0);
      end
      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // receiver stall pattern, with one long hold so the block backs up
   initial begin
      int seg_len;
      int stall_pct;
      while (reset) begin
         @(posedge clock);
      end
      forever begin
         if (long_hold_due) begin
            long_hold_due = 0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            seg_len = $urandom_range(8, 60);
            case ($urandom_range(0, 2))
               0: stall_pct = 0;
               1: stall_pct = 30;
               default: stall_pct = 75;
            endcase
            repeat (seg_len) begin
               rsp_stall <= ($urandom_range(0, 99) < stall_pct);
               @(posedge clock);
            end
         end
      end
   end

   // check each rsp transfer against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("result %0d unexpected: kind %0d status %0d slot %0d last %0d",
               results_seen, rsp_data.kind, rsp_data.status, rsp_data.result_slot,
               rsp_data.last));
         end else begin
            want_result = expected_results.pop_front();
            if (rsp_data.kind !== want_result.kind) begin
               report_mismatch($sformatf("result %0d kind got %0d want %0d",
                  results_seen, rsp_data.kind, want_result.kind));
            end
            if (rsp_data.status !== want_result.status) begin
               report_mismatch($sformatf("result %0d status got %0d want %0d",
                  results_seen, rsp_data.status, want_result.status));
            end
            if (rsp_data.result_slot !== want_result.result_slot) begin
               report_mismatch($sformatf("result %0d slot got %0d want %0d",
                  results_seen, rsp_data.result_slot, want_result.result_slot));
            end
            if (rsp_data.last !== want_result.last) begin
               report_mismatch($sformatf("result %0d last got %0d want %0d",
                  results_seen, rsp_data.last, want_result.last));
            end
         end
         results_seen++;
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still expected",
            cycle_count, expected_results.size());
         $display("FAIL");
         $finish;
      end
   end

   initial cycle_count = 0;

endmodule
